/* rtl/afp_pkg.sv */
// shared constants, types and helpers for the arm forward position block
`timescale 1ns / 1ps
package afp_pkg;

   localparam int ANGLE_BITS_DEFAULT = 16;
   localparam int TRIG_ITERATIONS_DEFAULT = 16;

   localparam int FIELD_W = 16;
   localparam int LINK_W = 16;
   localparam int OUT_W = 18;
   localparam int TURN_W = 32;
   localparam int CORDIC_W = 34;
   localparam int TRIG_W = 32;
   localparam int ATAN_LEN = 24;

   localparam logic [LINK_W-1:0] UPPER_LINK_RESET = 16'd11141;
   localparam logic [LINK_W-1:0] FORE_LINK_RESET = 16'd7209;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_UPPER_LINK = 1'b0,
      REG_FORE_LINK  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [LINK_W-1:0] upper_link;
      logic [LINK_W-1:0] fore_link;
   } link_cfg_type;

   // arctangent of 2^-i in 2^-32 turns
   function automatic logic signed [CORDIC_W-1:0] atan_turn(input int idx);
      logic signed [CORDIC_W-1:0] v;
      case (idx)
         0: v = 34'sd536870912;
         1: v = 34'sd316933406;
         2: v = 34'sd167458907;
         3: v = 34'sd85004756;
         4: v = 34'sd42667331;
         5: v = 34'sd21354465;
         6: v = 34'sd10679838;
         7: v = 34'sd5340245;
         8: v = 34'sd2670163;
         9: v = 34'sd1335087;
         10: v = 34'sd667544;
         11: v = 34'sd333772;
         12: v = 34'sd166886;
         13: v = 34'sd83443;
         14: v = 34'sd41722;
         15: v = 34'sd20861;
         16: v = 34'sd10430;
         17: v = 34'sd5215;
         18: v = 34'sd2608;
         19: v = 34'sd1304;
         20: v = 34'sd652;
         21: v = 34'sd326;
         22: v = 34'sd163;
         23: v = 34'sd81;
         default: v = '0;
      endcase
      return v;
   endfunction

   // clamp a wide signed value to the output range
   function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [65:0] v);
      logic signed [OUT_W-1:0] r;
      if (v > 66'sd131071) begin
         r = 18'sd131071;
      end else if (v < -66'sd131072) begin
         r = -18'sd131072;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

endpackage

/* rtl/arm_forward_position.sv */
// top level: joint angles in, saturated tool position out
//
//   channel | direction | ports
//   req     | in        | req_valid/ready, base/shoulder/elbow_angle
//   rsp     | out       | rsp_valid/ready, pos_x, pos_y, pos_z
//   csr     | in/out    | apb-style, link lengths at 0x0 and 0x4
//
// one word per cycle while the output word is taken; the latency is set by the
// cordic pipeline (fold, one stage per iteration, unfold) and three
// multiply/round stages plus the output register.
// reset clears the valid bits and loads the default link lengths; the whole
// pipeline freezes while the output word waits, so nothing is lost or repeated.
`timescale 1ns / 1ps
module arm_forward_position #(
   parameter int ANGLE_BITS = afp_pkg::ANGLE_BITS_DEFAULT,
   parameter int TRIG_ITERATIONS = afp_pkg::TRIG_ITERATIONS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [afp_pkg::FIELD_W-1:0]  req_base_angle,
   input  logic signed [afp_pkg::FIELD_W-1:0]  req_shoulder_angle,
   input  logic signed [afp_pkg::FIELD_W-1:0]  req_elbow_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [afp_pkg::OUT_W-1:0]    rsp_pos_x,
   output logic signed [afp_pkg::OUT_W-1:0]    rsp_pos_y,
   output logic signed [afp_pkg::OUT_W-1:0]    rsp_pos_z,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [afp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [afp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [afp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   localparam int FW = afp_pkg::FIELD_W;
   localparam int TW = afp_pkg::TURN_W;
   localparam int TRW = afp_pkg::TRIG_W;
   localparam int OW = afp_pkg::OUT_W;
   localparam int MASK_BITS = (ANGLE_BITS < FW) ? ANGLE_BITS : FW;
   localparam logic [FW-1:0] FIELD_MASK = FW'((64'd1 << MASK_BITS) - 64'd1);
   localparam int LAT = TRIG_ITERATIONS + 5;

   afp_pkg::link_cfg_type cfg;
   logic en;
   logic [TW-1:0] turn_b, turn_s, turn_se;
   logic signed [TRW-1:0] sb, cb, ss, cs, sse, cse;
   logic [LAT-1:0] valid_ff;

   // pipeline payload registers
   logic signed [48:0] p_cs_ff, p_cse_ff, p_ss_ff, p_sse_ff;
   logic signed [TRW-1:0] cb1_ff, sb1_ff, cb2_ff, sb2_ff;
   logic signed [33:0] rq_ff;
   logic signed [OW-1:0] z2_ff, z3_ff;
   logic signed [65:0] px_ff, py_ff;
   logic signed [49:0] r_sum, rz_sum;
   logic signed [65:0] px_rnd, py_rnd, z_rnd;
   logic rsp_valid_ff;
   logic signed [OW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;

   afp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign en = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // widen angles to 2^-32 turns; shoulder plus elbow wraps
   always_comb begin
      turn_b = TW'(req_base_angle & FIELD_MASK) << (TW - ANGLE_BITS);
      turn_s = TW'(req_shoulder_angle & FIELD_MASK) << (TW - ANGLE_BITS);
      turn_se = turn_s + (TW'(req_elbow_angle & FIELD_MASK) << (TW - ANGLE_BITS));
   end

   afp_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_b (
      .clock (clock), .en (en), .turn (turn_b), .sin_q (sb), .cos_q (cb)
   );
   afp_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_s (
      .clock (clock), .en (en), .turn (turn_s), .sin_q (ss), .cos_q (cs)
   );
   afp_cordic #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_trig_se (
      .clock (clock), .en (en), .turn (turn_se), .sin_q (sse), .cos_q (cse)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
         rsp_valid_ff <= valid_ff[LAT-1];
      end
   end

   // link products
   always_ff @(posedge clock) begin
      if (en) begin
         p_cs_ff <= 49'(signed'({1'b0, cfg.upper_link})) * 49'(cs);
         p_cse_ff <= 49'(signed'({1'b0, cfg.fore_link})) * 49'(cse);
         p_ss_ff <= 49'(signed'({1'b0, cfg.upper_link})) * 49'(ss);
         p_sse_ff <= 49'(signed'({1'b0, cfg.fore_link})) * 49'(sse);
         cb1_ff <= cb;
         sb1_ff <= sb;
      end
   end

   // sums, radial rounding to q14 and height rounding
   always_comb begin
      r_sum = 50'(p_cs_ff) + 50'(p_cse_ff);
      rz_sum = 50'(p_ss_ff) + 50'(p_sse_ff);
      z_rnd = (66'(rz_sum) + (66'sd1 <<< 29)) >>> 30;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rq_ff <= 34'((r_sum + (50'sd1 <<< 15)) >>> 16);
         z2_ff <= afp_pkg::sat_out(z_rnd);
         cb2_ff <= cb1_ff;
         sb2_ff <= sb1_ff;
      end
   end

   // base rotation
   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= 66'(rq_ff) * 66'(cb2_ff);
         py_ff <= 66'(rq_ff) * 66'(sb2_ff);
         z3_ff <= z2_ff;
      end
   end

   always_comb begin
      px_rnd = (px_ff + (66'sd1 <<< 43)) >>> 44;
      py_rnd = (py_ff + (66'sd1 <<< 43)) >>> 44;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff <= afp_pkg::sat_out(px_rnd);
         pos_y_ff <= afp_pkg::sat_out(py_rnd);
         pos_z_ff <= z3_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_pos_z = pos_z_ff;
endmodule

/* rtl/afp_cordic_stage.sv */
// one registered cordic micro-rotation
`timescale 1ns / 1ps
module afp_cordic_stage #(
   parameter int IDX = 0
) (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic signed [afp_pkg::CORDIC_W-1:0]    x_d,
   input  logic signed [afp_pkg::CORDIC_W-1:0]    y_d,
   input  logic signed [afp_pkg::CORDIC_W-1:0]    z_d,
   output logic signed [afp_pkg::CORDIC_W-1:0]    x_q,
   output logic signed [afp_pkg::CORDIC_W-1:0]    y_q,
   output logic signed [afp_pkg::CORDIC_W-1:0]    z_q
);
   localparam logic signed [afp_pkg::CORDIC_W-1:0] ATAN = afp_pkg::atan_turn(IDX);

   logic signed [afp_pkg::CORDIC_W-1:0] x_ff, y_ff, z_ff;
   logic signed [afp_pkg::CORDIC_W-1:0] x_in, y_in, z_in;
   logic signed [afp_pkg::CORDIC_W-1:0] dx, dy;

   always_comb begin
      dx = y_d >>> IDX;
      dy = x_d >>> IDX;
      if (!z_d[afp_pkg::CORDIC_W-1]) begin
         x_in = x_d - dx;
         y_in = y_d + dy;
         z_in = z_d - ATAN;
      end else begin
         x_in = x_d + dx;
         y_in = y_d - dy;
         z_in = z_d + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_q = x_ff;
   assign y_q = y_ff;
   assign z_q = z_ff;
endmodule

/* rtl/afp_cordic.sv */
// pipelined sine/cosine unit: quadrant fold, micro-rotations, unfold
`timescale 1ns / 1ps
module afp_cordic #(
   parameter int TRIG_ITERATIONS = afp_pkg::TRIG_ITERATIONS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic [afp_pkg::TURN_W-1:0]           turn,
   output logic signed [afp_pkg::TRIG_W-1:0]    sin_q,
   output logic signed [afp_pkg::TRIG_W-1:0]    cos_q
);
   localparam int CW = afp_pkg::CORDIC_W;
   localparam int TW = afp_pkg::TURN_W;

   logic                 flip_in;
   logic [TW-1:0]        fold;
   logic signed [CW-1:0] z_ff;
   logic [TRIG_ITERATIONS:0] flip_ff;
   logic signed [CW-1:0] xs [TRIG_ITERATIONS+1];
   logic signed [CW-1:0] ys [TRIG_ITERATIONS+1];
   logic signed [CW-1:0] zs [TRIG_ITERATIONS+1];
   logic signed [afp_pkg::TRIG_W-1:0] sin_ff, cos_ff;
   logic signed [CW-1:0] xn, yn;

   // angles in the left half plane are turned by half a turn
   always_comb begin
      flip_in = (turn + 32'h4000_0000) >> (TW - 1) != '0;
      fold = turn ^ {flip_in, {(TW-1){1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff <= CW'(signed'(fold));
         flip_ff <= {flip_ff[TRIG_ITERATIONS-1:0], flip_in};
      end
   end

   assign xs[0] = afp_pkg::CORDIC_GAIN;
   assign ys[0] = '0;
   assign zs[0] = z_ff;

   for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_stage
      afp_cordic_stage #(.IDX(i)) u_stage (
         .clock (clock),
         .en    (en),
         .x_d   (xs[i]),
         .y_d   (ys[i]),
         .z_d   (zs[i]),
         .x_q   (xs[i+1]),
         .y_q   (ys[i+1]),
         .z_q   (zs[i+1])
      );
   end

   always_comb begin
      xn = flip_ff[TRIG_ITERATIONS] ? -xs[TRIG_ITERATIONS] : xs[TRIG_ITERATIONS];
      yn = flip_ff[TRIG_ITERATIONS] ? -ys[TRIG_ITERATIONS] : ys[TRIG_ITERATIONS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_ff <= xn[afp_pkg::TRIG_W-1:0];
         sin_ff <= yn[afp_pkg::TRIG_W-1:0];
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;
endmodule

/* rtl/afp_csr.sv */
// link length registers behind the apb-style port
`timescale 1ns / 1ps
module afp_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [afp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [afp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [afp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready,
   output afp_pkg::link_cfg_type               cfg
);
   afp_pkg::link_cfg_type cfg_ff;
   afp_pkg::csr_index_type idx;
   logic wr;

   assign idx = afp_pkg::csr_index_type'(csr_paddr[2]);
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.upper_link <= afp_pkg::UPPER_LINK_RESET;
         cfg_ff.fore_link <= afp_pkg::FORE_LINK_RESET;
      end else if (wr) begin
         case (idx)
            afp_pkg::REG_UPPER_LINK: cfg_ff.upper_link <= csr_pwdata[afp_pkg::LINK_W-1:0];
            afp_pkg::REG_FORE_LINK:  cfg_ff.fore_link <= csr_pwdata[afp_pkg::LINK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         afp_pkg::REG_UPPER_LINK: csr_prdata = 32'(cfg_ff.upper_link);
         afp_pkg::REG_FORE_LINK:  csr_prdata = 32'(cfg_ff.fore_link);
         default: csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg = cfg_ff;
endmodule

/* sim/arm_forward_position_tb.sv */
// self-checking testbench for the arm forward position block
`timescale 1ns / 1ps
module arm_forward_position_tb;

   localparam int LATENCY = afp_pkg::TRIG_ITERATIONS_DEFAULT + 6;
   localparam int N_RANDOM = 1450;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic signed [afp_pkg::OUT_W-1:0] x;
      logic signed [afp_pkg::OUT_W-1:0] y;
      logic signed [afp_pkg::OUT_W-1:0] z;
   } position_type;

   typedef struct {
      logic signed [afp_pkg::FIELD_W-1:0] b;
      logic signed [afp_pkg::FIELD_W-1:0] s;
      logic signed [afp_pkg::FIELD_W-1:0] e;
      bit                                 known;
      position_type                       pos;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [afp_pkg::FIELD_W-1:0] req_base_angle = '0;
   logic signed [afp_pkg::FIELD_W-1:0] req_shoulder_angle = '0;
   logic signed [afp_pkg::FIELD_W-1:0] req_elbow_angle = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [afp_pkg::OUT_W-1:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [afp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [afp_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [afp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   arm_forward_position u_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   logic [afp_pkg::LINK_W-1:0] upper_len, fore_len;
   position_type pending_pos[$];
   int errors = 0;
   int cycles = 0;
   bit stall_long = 1'b0;

   task automatic report(input string what, input position_type got, input position_type want);
      errors++;
      $display("mismatch %s: got %0d %0d %0d want %0d %0d %0d", what,
               got.x, got.y, got.z, want.x, want.y, want.z);
   endtask

   // arithmetic shift right with floor on a 64-bit signed value
   function automatic longint floor_shift(input longint v, input int sh);
      return v >>> sh;
   endfunction

   function automatic void trig(input logic [afp_pkg::TURN_W-1:0] a, output longint sn,
                                output longint cs);
      bit flip;
      longint x, y, z, dx, dy;
      flip = ((a + 32'h4000_0000) & 32'h8000_0000) != 0;
      if (flip) a = a - 32'h8000_0000;
      x = 652032874;
      y = 0;
      z = longint'($signed(a));
      for (int i = 0; i < afp_pkg::TRIG_ITERATIONS_DEFAULT; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(afp_pkg::atan_turn(i));
         end else begin
            x += dx; y -= dy; z += longint'(afp_pkg::atan_turn(i));
         end
      end
      cs = flip ? -x : x;
      sn = flip ? -y : y;
   endfunction

   function automatic logic signed [afp_pkg::OUT_W-1:0] clamp(input longint v);
      if (v > 131071) return 18'sd131071;
      if (v < -131072) return -18'sd131072;
      return v[afp_pkg::OUT_W-1:0];
   endfunction

   function automatic position_type tool_position(input logic [afp_pkg::FIELD_W-1:0] b,
         input logic [afp_pkg::FIELD_W-1:0] s, input logic [afp_pkg::FIELD_W-1:0] e);
      longint sb, cb, ss, cs, sse, cse, r, rz, rq, l1, l2;
      logic [afp_pkg::TURN_W-1:0] tb, ts, tse;
      position_type p;
      tb = {b, 16'h0};
      ts = {s, 16'h0};
      tse = ts + {e, 16'h0};
      trig(tb, sb, cb);
      trig(ts, ss, cs);
      trig(tse, sse, cse);
      l1 = upper_len;
      l2 = fore_len;
      r = l1 * cs + l2 * cse;
      rz = l1 * ss + l2 * sse;
      rq = floor_shift(r + (64'sd1 <<< 15), 16);
      p.x = clamp(floor_shift(rq * cb + (64'sd1 <<< 43), 44));
      p.y = clamp(floor_shift(rq * sb + (64'sd1 <<< 43), 44));
      p.z = clamp(floor_shift(rz + (64'sd1 <<< 29), 30));
      return p;
   endfunction

   task automatic csr_write(input afp_pkg::csr_index_type idx,
                            input logic [afp_pkg::CSR_DATA_W-1:0] v);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= afp_pkg::CSR_ADDR_W'(idx) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (idx == afp_pkg::REG_UPPER_LINK) upper_len = v[afp_pkg::LINK_W-1:0];
      else fore_len = v[afp_pkg::LINK_W-1:0];
   endtask

   // valid stays up across back-to-back words; it drops only before a gap
   task automatic send_word(input logic [afp_pkg::FIELD_W-1:0] b,
                            input logic [afp_pkg::FIELD_W-1:0] s,
                            input logic [afp_pkg::FIELD_W-1:0] e, input bit known,
                            input position_type want);
      position_type p;
      int gap;
      gap = $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      p = tool_position(b, s, e);
      if (known && p != want) report("table", p, want);
      pending_pos.push_back(p);
      req_valid <= 1'b1;
      req_base_angle <= b;
      req_shoulder_angle <= s;
      req_elbow_angle <= e;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic [afp_pkg::FIELD_W-1:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h4000 + 16'($urandom_range(0, 6)) - 16'd3;
         3: return 16'hc000 + 16'($urandom_range(0, 6)) - 16'd3;
         default: return 16'($urandom);
      endcase
   endfunction

   // result side: random gaps, one long hold-off while the sender keeps going
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         if (stall_long) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            stall_long = 1'b0;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      position_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_pos_x, rsp_pos_y, rsp_pos_z};
         if (pending_pos.size() == 0) begin
            report("unexpected word", got, got);
         end else if (got != pending_pos[0]) begin
            report("position", got, pending_pos.pop_front());
         end else begin
            void'(pending_pos.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   stim_row_type stim_table[$];

   initial begin
      logic [afp_pkg::CSR_DATA_W-1:0] lens[6][2];
      lens = '{'{32'd11141, 32'd7209}, '{32'hffff, 32'hffff}, '{32'd0, 32'd0},
               '{32'h0001_2345, 32'd0}, '{32'd0, 32'hfffe_ffff}, '{32'h5555, 32'haaaa}};
      upper_len = afp_pkg::UPPER_LINK_RESET;
      fore_len = afp_pkg::FORE_LINK_RESET;
      // zero angles at reset lengths: arm stretched along x
      stim_table.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b0, '0});
      stim_table.push_back('{-16'sd32768, 16'sd0, 16'sd0, 1'b0, '0});
      stim_table.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0});
      stim_table.push_back('{16'sh4000, 16'sh4000, 16'sd0, 1'b0, '0});
      stim_table.push_back('{16'shc000, 16'shc000, -16'sd32768, 1'b0, '0});
      stim_table.push_back('{16'sh2000, 16'sh3fff, 16'sh4001, 1'b0, '0});
      stim_table.push_back('{16'sh1234, -16'sd32768, -16'sd32768, 1'b0, '0});
      stim_table.push_back('{16'shffff, 16'sh0001, 16'shffff, 1'b0, '0});
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_table[i])
         send_word(stim_table[i].b, stim_table[i].s, stim_table[i].e,
                   stim_table[i].known, stim_table[i].pos);
      drain();
      // all-zero lengths give the origin, max lengths reach the range edge
      csr_write(afp_pkg::REG_UPPER_LINK, 32'd0);
      csr_write(afp_pkg::REG_FORE_LINK, 32'd0);
      send_word(16'h1111, 16'h2222, 16'h3333, 1'b1, '0);
      drain();
      csr_write(afp_pkg::REG_UPPER_LINK, 32'hffff);
      csr_write(afp_pkg::REG_FORE_LINK, 32'hffff);
      send_word(16'h0000, 16'h0000, 16'h0000, 1'b0, '0);
      send_word(16'h0000, 16'h4000, 16'h0000, 1'b0, '0);
      send_word(16'h0000, 16'hc000, 16'h0000, 1'b0, '0);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(afp_pkg::REG_UPPER_LINK, lens[ph][0]);
         csr_write(afp_pkg::REG_FORE_LINK, lens[ph][1]);
         if (ph == 2) stall_long = 1'b1;
         for (int n = 0; n < N_RANDOM / 6; n++)
            send_word(rand_angle(), rand_angle(), rand_angle(), 1'b0, '0);
         drain();
      end
      if (errors == 0 && pending_pos.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
